// File: design/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared constants and types of the line-of-sight terrain obstacle scan.
// ----------------------------------------------------------------------------
package lts_pkg;

    // grid geometry
    localparam int GRID_SIDE = 256;
    localparam int GRID_BITS = $clog2(GRID_SIDE);
    localparam int ADDR_W    = 2 * GRID_BITS;

    // field widths
    localparam int ELEV_W  = 18;
    localparam int POS_W   = 16;
    localparam int TILT_W  = 24;
    localparam int STEP_W  = 13;
    localparam int CELL_W  = 8;
    localparam int HGT_W   = 24;
    localparam int DIST_W  = 17;

    // reset value of the sampling step
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // result when no sample beats the floor
    localparam logic signed [HGT_W-1:0] NONE_HEIGHT = -HGT_W'(160000);

    // shift-subtract unit sizing
    localparam int SRC_W     = 50;
    localparam int ROOT_W    = 25;
    localparam int NUM_W     = 29;
    localparam int UREM_W    = 28;
    localparam int URES_W    = 29;
    localparam int CNT_W     = 5;
    localparam int SQRT_ITER = SRC_W / 2;
    localparam int DIV_ITER  = NUM_W;

    // request to the shift-subtract unit
    typedef struct packed {
        logic              start;
        logic              is_sqrt;
        logic [SRC_W-1:0]  src;
        logic [ROOT_W-1:0] divisor;
    } t_unit_req;

    // response of the shift-subtract unit
    typedef struct packed {
        logic              done;
        logic [URES_W-1:0] res;
        logic [UREM_W-1:0] rem;
    } t_unit_rsp;

endpackage

// File: design/lts_ifs.sv
// ----------------------------------------------------------------------------
// lts channel interfaces
// Valid/ready channels for input items, result items and the step register.
// ----------------------------------------------------------------------------
interface lts_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic [lts_pkg::CELL_W-1:0]             cell_x;
    logic [lts_pkg::CELL_W-1:0]             cell_y;
    logic signed [lts_pkg::ELEV_W-1:0]      elevation;
    logic [lts_pkg::POS_W-1:0]              bs_x;
    logic [lts_pkg::POS_W-1:0]              bs_y;
    logic [lts_pkg::POS_W-1:0]              ms_x;
    logic [lts_pkg::POS_W-1:0]              ms_y;
    logic signed [lts_pkg::ELEV_W-1:0]      tx_height;
    logic signed [lts_pkg::TILT_W-1:0]      los_tilt;

    modport source (output valid, action, cell_x, cell_y, elevation, bs_x, bs_y,
                    ms_x, ms_y, tx_height, los_tilt, input ready);
    modport sink   (input valid, action, cell_x, cell_y, elevation, bs_x, bs_y,
                    ms_x, ms_y, tx_height, los_tilt, output ready);
endinterface

interface lts_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lts_pkg::HGT_W-1:0]  obstacle_height;
    logic [lts_pkg::DIST_W-1:0]        obstacle_distance;

    modport source (output valid, obstacle_height, obstacle_distance, input ready);
    modport sink   (input valid, obstacle_height, obstacle_distance, output ready);
endinterface

interface lts_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lts_pkg::STEP_W-1:0]   step_length;

    modport source (output valid, step_length, input ready);
    modport sink   (input valid, step_length, output ready);
endinterface

// File: design/lts_shift_sub.sv
// ----------------------------------------------------------------------------
// lts_shift_sub
// Shared shift-subtract unit: integer square root (two bits per cycle) or
// unsigned division (one bit per cycle).
// ----------------------------------------------------------------------------
module lts_shift_sub (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lts_pkg::t_unit_req i_req,
    output lts_pkg::t_unit_rsp o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic                               r_sqrt;
    logic [lts_pkg::CNT_W-1:0]          r_cnt;
    logic [lts_pkg::SRC_W-1:0]          r_src;
    logic [lts_pkg::ROOT_W-1:0]         r_div;
    logic [lts_pkg::URES_W-1:0]         r_res;
    logic [lts_pkg::UREM_W-1:0]         r_rem;

    logic [lts_pkg::UREM_W-1:0]         rem_sh;
    logic [lts_pkg::UREM_W-1:0]         trial;
    logic                               ge;
    logic [lts_pkg::CNT_W-1:0]          last;

    // one digit step
    always_comb begin
        if (r_sqrt) begin
            rem_sh = {r_rem[lts_pkg::UREM_W-3:0], r_src[lts_pkg::SRC_W-1 -: 2]};
            trial  = {r_res[lts_pkg::UREM_W-3:0], 2'b01};
            last   = lts_pkg::CNT_W'(lts_pkg::SQRT_ITER - 1);
        end else begin
            rem_sh = {r_rem[lts_pkg::UREM_W-2:0], r_src[lts_pkg::SRC_W-1]};
            trial  = lts_pkg::UREM_W'(r_div);
            last   = lts_pkg::CNT_W'(lts_pkg::DIV_ITER - 1);
        end
        ge = (rem_sh >= trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.is_sqrt;
            r_src  <= i_req.src;
            r_div  <= i_req.divisor;
            r_res  <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - trial) : rem_sh;
            r_res <= {r_res[lts_pkg::URES_W-2:0], ge};
            r_src <= r_sqrt ? {r_src[lts_pkg::SRC_W-3:0], 2'b00}
                            : {r_src[lts_pkg::SRC_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
    assign o_rsp.rem  = r_rem;

endmodule

// File: design/lts_elev_ram.sv
// ----------------------------------------------------------------------------
// lts_elev_ram
// Elevation grid store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lts_elev_ram (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [lts_pkg::ADDR_W-1:0]          i_waddr,
    input  logic signed [lts_pkg::ELEV_W-1:0]   i_wdata,
    input  logic [lts_pkg::ADDR_W-1:0]          i_raddr,
    output logic signed [lts_pkg::ELEV_W-1:0]   o_rdata
);

    logic signed [lts_pkg::ELEV_W-1:0] r_mem [lts_pkg::GRID_SIDE*lts_pkg::GRID_SIDE];
    logic signed [lts_pkg::ELEV_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/los_terrain_obstacle_scan.sv
// ----------------------------------------------------------------------------
// los_terrain_obstacle_scan
// Line-of-sight obstacle scan over an elevation grid, walked from the
// transmitter toward the receiver with a shared shift-subtract unit.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  i_cfg    in   step_length register write
//  i_in     in   cell write or profile query
//  o_out    out  obstacle_height, obstacle_distance (queries only)
//
//  After reset a clearing pass zeroes the grid, one cell per cycle;
//  i_in.ready stays low meanwhile, register writes are still taken.
//  A cell write is done as it is accepted. A query first runs a setup
//  (the square root and two divisions in the shift-subtract unit), then
//  one grid read per sample for about distance/step_length samples.
//  One result register decouples o_out; a query only waits at its end while
//  the previous result has not been transferred.
// ----------------------------------------------------------------------------
module los_terrain_obstacle_scan (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lts_cfg_if.sink    i_cfg,
    lts_in_if.sink     i_in,
    lts_out_if.source  o_out
);

    typedef enum logic [18:0] {
        ST_CLEAR     = 19'h00001,
        ST_IDLE      = 19'h00002,
        ST_MUL_DX    = 19'h00004,
        ST_MUL_DY    = 19'h00008,
        ST_SQRT_GO   = 19'h00010,
        ST_SQRT_WAIT = 19'h00020,
        ST_MUL_TILT  = 19'h00040,
        ST_MUL_SX    = 19'h00080,
        ST_DIVX_GO   = 19'h00100,
        ST_DIVX_WAIT = 19'h00200,
        ST_MUL_SY    = 19'h00400,
        ST_DIVY_GO   = 19'h00800,
        ST_DIVY_WAIT = 19'h01000,
        ST_MUL_PX    = 19'h02000,
        ST_MUL_PY    = 19'h04000,
        ST_ADV       = 19'h08000,
        ST_CHK       = 19'h10000,
        ST_RD        = 19'h20000,
        ST_FINISH    = 19'h40000
    } t_state;

    localparam int IDX_W  = 14;
    localparam int QS_W   = 33;
    localparam int INCQ_W = 8;
    localparam int T_W    = 42;
    localparam int DD_W   = 34;

    t_state r_state, n_state;

    logic [lts_pkg::STEP_W-1:0]           r_step;
    logic [lts_pkg::ADDR_W-1:0]           r_clr;
    logic                                 r_out_valid;
    logic signed [lts_pkg::HGT_W-1:0]     r_out_h;
    logic [lts_pkg::DIST_W-1:0]           r_out_d;

    // query working registers
    logic [lts_pkg::POS_W-1:0]            r_bx, r_by;
    logic signed [lts_pkg::POS_W:0]       r_dx, r_dy;
    logic signed [lts_pkg::ELEV_W-1:0]    r_tx;
    logic signed [lts_pkg::TILT_W-1:0]    r_tilt;
    logic [QS_W-1:0]                      r_s;
    logic [lts_pkg::ROOT_W-1:0]           r_q;
    logic signed [T_W-1:0]                r_t, r_tinc;
    logic [lts_pkg::NUM_W-1:0]            r_num;
    logic                                 r_neg;
    logic signed [INCQ_W-1:0]             r_incq_x, r_incq_y;
    logic [QS_W-1:0]                      r_incr_x, r_incr_y;
    logic signed [IDX_W-1:0]              r_qx, r_qy;
    logic [QS_W-1:0]                      r_rx, r_ry;
    logic [lts_pkg::DIST_W-1:0]           r_d;
    logic [DD_W-1:0]                      r_dd;
    logic signed [lts_pkg::HGT_W-1:0]     r_best;
    logic [lts_pkg::DIST_W-1:0]           r_best_d;

    logic                                 in_xfer, out_xfer;
    logic signed [25:0]                   m_a;
    logic signed [24:0]                   m_b;
    logic signed [50:0]                   m_p;
    lts_pkg::t_unit_req                   u_req;
    lts_pkg::t_unit_rsp                   u_rsp;
    logic [lts_pkg::DIST_W-1:0]           d_next;
    logic [QS_W-1:0]                      q256;
    logic [QS_W:0]                        sum_x, sum_y;
    logic                                 wrap_x, wrap_y;
    logic [lts_pkg::GRID_BITS-1:0]        ix, iy;
    logic signed [lts_pkg::ELEV_W-1:0]    rd_elev;
    logic signed [24:0]                   h_raw;
    logic signed [lts_pkg::HGT_W-1:0]     h_sat;
    logic [lts_pkg::URES_W-1:0]           qa;
    logic [lts_pkg::ROOT_W-1:0]           ra;
    logic signed [INCQ_W-1:0]             fix_q;
    logic [lts_pkg::ROOT_W-1:0]           fix_r;
    logic                                 ram_we;
    logic [lts_pkg::ADDR_W-1:0]           ram_waddr;
    logic signed [lts_pkg::ELEV_W-1:0]    ram_wdata;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_out_valid && o_out.ready;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid             = r_out_valid;
    assign o_out.obstacle_height   = r_out_h;
    assign o_out.obstacle_distance = r_out_d;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_MUL_DX: begin
                m_a = 26'(r_dx);
                m_b = 25'(r_dx);
            end
            ST_MUL_DY: begin
                m_a = 26'(r_dy);
                m_b = 25'(r_dy);
            end
            ST_MUL_TILT: begin
                m_a = 26'($signed({1'b0, r_step}));
                m_b = 25'(r_tilt);
            end
            ST_MUL_SX: begin
                m_a = 26'($signed({1'b0, r_step}));
                m_b = 25'(r_dx);
            end
            ST_MUL_SY: begin
                m_a = 26'($signed({1'b0, r_step}));
                m_b = 25'(r_dy);
            end
            ST_MUL_PX: begin
                m_a = 26'($signed({1'b0, r_q}));
                m_b = 25'($signed({1'b0, 8'(r_bx + 16'd128)}));
            end
            ST_MUL_PY: begin
                m_a = 26'($signed({1'b0, r_q}));
                m_b = 25'($signed({1'b0, 8'(r_by + 16'd128)}));
            end
            ST_ADV, ST_RD: begin
                m_a = 26'($signed({1'b0, d_next}));
                m_b = 25'($signed({1'b0, d_next}));
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_p = 51'(m_a) * 51'(m_b);
    end

    // shift-subtract unit requests
    always_comb begin
        u_req.start   = (r_state == ST_SQRT_GO) || (r_state == ST_DIVX_GO)
                        || (r_state == ST_DIVY_GO);
        u_req.is_sqrt = (r_state == ST_SQRT_GO);
        u_req.src     = (r_state == ST_SQRT_GO)
                        ? lts_pkg::SRC_W'({r_s, 16'b0})
                        : {r_num, (lts_pkg::SRC_W - lts_pkg::NUM_W)'(0)};
        u_req.divisor = r_q;
    end

    lts_shift_sub u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .o_rsp   (u_rsp)
    );

    // floor correction of the quotient for a negative direction
    always_comb begin
        qa = u_rsp.res;
        ra = u_rsp.rem[lts_pkg::ROOT_W-1:0];
        if (r_neg && (ra != '0)) begin
            fix_q = -INCQ_W'(qa) - INCQ_W'(1);
            fix_r = r_q - ra;
        end else if (r_neg) begin
            fix_q = -INCQ_W'(qa);
            fix_r = '0;
        end else begin
            fix_q = INCQ_W'(qa);
            fix_r = ra;
        end
    end

    // sample advance: distance, cell quotient and remainder per axis
    always_comb begin
        d_next = r_d + lts_pkg::DIST_W'(r_step);
        q256   = {r_q, 8'b0};
        sum_x  = {1'b0, r_rx} + {1'b0, r_incr_x};
        sum_y  = {1'b0, r_ry} + {1'b0, r_incr_y};
        wrap_x = (sum_x >= {1'b0, q256});
        wrap_y = (sum_y >= {1'b0, q256});
    end

    // clamp the cell index into the grid
    always_comb begin
        if (r_qx < 0) begin
            ix = '0;
        end else if (r_qx > IDX_W'(lts_pkg::GRID_SIDE - 1)) begin
            ix = lts_pkg::GRID_BITS'(lts_pkg::GRID_SIDE - 1);
        end else begin
            ix = r_qx[lts_pkg::GRID_BITS-1:0];
        end
        if (r_qy < 0) begin
            iy = '0;
        end else if (r_qy > IDX_W'(lts_pkg::GRID_SIDE - 1)) begin
            iy = lts_pkg::GRID_BITS'(lts_pkg::GRID_SIDE - 1);
        end else begin
            iy = r_qy[lts_pkg::GRID_BITS-1:0];
        end
    end

    // height above line of sight, saturated
    always_comb begin
        h_raw = 25'(rd_elev) - 25'(r_tx) - 25'($signed(r_t[T_W-1:20]));
        if (h_raw > 25'sd8388607) begin
            h_sat = 24'sh7FFFFF;
        end else if (h_raw < -25'sd8388608) begin
            h_sat = 24'sh800000;
        end else begin
            h_sat = h_raw[lts_pkg::HGT_W-1:0];
        end
    end

    // grid write port: clearing pass or cell write
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            ram_we    = in_xfer && (i_in.action == lts_pkg::ACT_WRITE)
                        && (32'(i_in.cell_x) < lts_pkg::GRID_SIDE)
                        && (32'(i_in.cell_y) < lts_pkg::GRID_SIDE);
            ram_waddr = {lts_pkg::GRID_BITS'(i_in.cell_x),
                         lts_pkg::GRID_BITS'(i_in.cell_y)};
            ram_wdata = i_in.elevation;
        end
    end

    lts_elev_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr ({ix, iy}),
        .o_rdata (rd_elev)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:     if (&r_clr) n_state = ST_IDLE;
            ST_IDLE:      if (in_xfer && (i_in.action == lts_pkg::ACT_QUERY)) begin
                              n_state = ST_MUL_DX;
                          end
            ST_MUL_DX:    n_state = ST_MUL_DY;
            ST_MUL_DY:    n_state = ST_SQRT_GO;
            ST_SQRT_GO:   n_state = ST_SQRT_WAIT;
            ST_SQRT_WAIT: if (u_rsp.done) begin
                              n_state = ((r_step == '0) || (r_s == '0)) ? ST_FINISH
                                                                       : ST_MUL_TILT;
                          end
            ST_MUL_TILT:  n_state = ST_MUL_SX;
            ST_MUL_SX:    n_state = ST_DIVX_GO;
            ST_DIVX_GO:   n_state = ST_DIVX_WAIT;
            ST_DIVX_WAIT: if (u_rsp.done) n_state = ST_MUL_SY;
            ST_MUL_SY:    n_state = ST_DIVY_GO;
            ST_DIVY_GO:   n_state = ST_DIVY_WAIT;
            ST_DIVY_WAIT: if (u_rsp.done) n_state = ST_MUL_PX;
            ST_MUL_PX:    n_state = ST_MUL_PY;
            ST_MUL_PY:    n_state = ST_ADV;
            ST_ADV:       n_state = ST_CHK;
            ST_CHK:       n_state = (r_dd >= DD_W'(r_s)) ? ST_FINISH : ST_RD;
            ST_RD:        n_state = ST_CHK;
            ST_FINISH:    if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_step      <= lts_pkg::STEP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_step <= i_cfg.step_length;
            end
            if ((r_state == ST_FINISH) && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FINISH) && (!r_out_valid || o_out.ready)) begin
            r_out_h <= r_best;
            r_out_d <= r_best_d;
        end
    end

    // query datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_bx     <= i_in.bs_x;
                r_by     <= i_in.bs_y;
                r_dx     <= $signed({1'b0, i_in.ms_x}) - $signed({1'b0, i_in.bs_x});
                r_dy     <= $signed({1'b0, i_in.ms_y}) - $signed({1'b0, i_in.bs_y});
                r_tx     <= i_in.tx_height;
                r_tilt   <= i_in.los_tilt;
                r_best   <= lts_pkg::NONE_HEIGHT;
                r_best_d <= '0;
            end
            ST_MUL_DX: r_s <= QS_W'(m_p);
            ST_MUL_DY: r_s <= r_s + QS_W'(m_p);
            ST_SQRT_WAIT: if (u_rsp.done) begin
                r_q <= u_rsp.res[lts_pkg::ROOT_W-1:0];
            end
            ST_MUL_TILT: begin
                r_tinc <= T_W'(m_p);
                r_t    <= T_W'(1 << 19);
                r_d    <= '0;
            end
            ST_MUL_SX, ST_MUL_SY: begin
                r_neg <= m_p[50];
                r_num <= m_p[50] ? lts_pkg::NUM_W'(-m_p) : lts_pkg::NUM_W'(m_p);
            end
            ST_DIVX_WAIT: if (u_rsp.done) begin
                r_incq_x <= fix_q;
                r_incr_x <= {fix_r, 8'b0};
            end
            ST_DIVY_WAIT: if (u_rsp.done) begin
                r_incq_y <= fix_q;
                r_incr_y <= {fix_r, 8'b0};
            end
            ST_MUL_PX: begin
                r_rx <= QS_W'(m_p);
                r_qx <= IDX_W'((17'(r_bx) + 17'd128) >> 8);
            end
            ST_MUL_PY: begin
                r_ry <= QS_W'(m_p);
                r_qy <= IDX_W'((17'(r_by) + 17'd128) >> 8);
            end
            ST_ADV, ST_RD: begin
                // keep the first of equal heights
                if ((r_state == ST_RD) && (h_sat > r_best)) begin
                    r_best   <= h_sat;
                    r_best_d <= r_d;
                end
                r_d  <= d_next;
                r_dd <= DD_W'(m_p);
                r_t  <= r_t + r_tinc;
                r_rx <= wrap_x ? QS_W'(sum_x - {1'b0, q256}) : QS_W'(sum_x);
                r_ry <= wrap_y ? QS_W'(sum_y - {1'b0, q256}) : QS_W'(sum_y);
                r_qx <= r_qx + IDX_W'(r_incq_x) + IDX_W'(wrap_x);
                r_qy <= r_qy + IDX_W'(r_incq_y) + IDX_W'(wrap_y);
            end
            default: begin
            end
        endcase
    end

endmodule
